### rtl/ptdp_pkg.sv
// Shared types and constants for the point-to-depth-pixel projection core.
`default_nettype none

package ptdp_pkg;

    localparam int COORD_W       = 32;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int SIZE_W        = 13;
    localparam int PIX_W         = 12;
    localparam int DEPTH_W       = 16;
    localparam int DEF_MAX_ROWS  = 4096;
    localparam int DEF_MAX_COLS  = 4096;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int PROD_W        = CFG_W + COORD_W + 1;
    localparam int NUM_W         = PROD_W + 1;
    localparam int FRAC_W        = 8;
    localparam int DEN_W         = COORD_W - 1 + FRAC_W;
    localparam int REM_W         = DEN_W + PIX_W;
    localparam int MM_CONST      = 1000;
    localparam int MM_W          = 10;
    localparam int ZK_W          = COORD_W - 1 + MM_W;
    localparam int DEPTH_SHIFT   = 16;
    localparam int ROUND_HALF    = 1 << (DEPTH_SHIFT - 1);
    localparam int RST_ROWS      = 720;
    localparam int RST_COLS      = 1280;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_SKEW,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_IMAGE_ROWS,
        REG_IMAGE_COLS
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic               in_range;
        logic [PIX_W-1:0]   pixel_row;
        logic [PIX_W-1:0]   pixel_col;
        logic [DEPTH_W-1:0] depth_mm;
    } pixel_t;

    typedef struct packed {
        point_t pt;
        logic   z_pos;
    } queue_entry_t;

    typedef struct packed {
        logic [CFG_W-1:0]        focal_x;
        logic [CFG_W-1:0]        focal_y;
        logic signed [CFG_W-1:0] skew_term;
        logic [CFG_W-1:0]        center_x;
        logic [CFG_W-1:0]        center_y;
        logic [SIZE_W-1:0]       image_rows;
        logic [SIZE_W-1:0]       image_cols;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/ptdp_front.sv
// Front end: accepts point requests, flags positive depth, and queues them for the back end.
`default_nettype none

module ptdp_front import ptdp_pkg::*; (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  point_t       s_data,
    output logic         q_valid,
    output queue_entry_t q_data,
    input  wire          q_pop
);

    queue_entry_t         entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;
    logic                 push;
    queue_entry_t         new_entry;

    assign s_ready = (count_reg != (Q_PTR_W+1)'(Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        new_entry.pt    = s_data;
        new_entry.z_pos = !s_data.point_z[COORD_W-1] && (s_data.point_z != '0);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/ptdp_div_step.sv
// One restoring-division step: resolves a single quotient bit of a pixel coordinate.
`default_nettype none

module ptdp_div_step import ptdp_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  wire  [REM_W-1:0] rem_in,
    input  wire  [DEN_W-1:0] den,
    input  wire  [PIX_W-1:0] q_in,
    output logic [REM_W-1:0] rem_out,
    output logic [PIX_W-1:0] q_out
);

    logic [REM_W-1:0] den_sh;
    logic             ge;

    always_comb begin
        den_sh      = REM_W'(den) << SHIFT;
        ge          = (rem_in >= den_sh);
        rem_out     = ge ? (rem_in - den_sh) : rem_in;
        q_out       = q_in;
        q_out[SHIFT] = ge;
    end

endmodule

`default_nettype wire

### rtl/ptdp_back.sv
// Back end: multiply, sum, range check, bit-per-stage division and output register.
`default_nettype none

module ptdp_back import ptdp_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  cfg_t         cfg,
    input  wire          q_valid,
    input  queue_entry_t q_data,
    output logic         q_pop,
    output logic         m_valid,
    input  wire          m_ready,
    output pixel_t       m_data
);

    localparam int PIX_LIMIT = 1 << PIX_W;
    localparam int ROW_CAP   = (MAX_ROWS < PIX_LIMIT) ? MAX_ROWS : PIX_LIMIT;
    localparam int COL_CAP   = (MAX_COLS < PIX_LIMIT) ? MAX_COLS : PIX_LIMIT;

    typedef struct packed {
        logic                     z_pos;
        logic signed [PROD_W-1:0] fx_x;
        logic signed [PROD_W-1:0] sk_y;
        logic signed [PROD_W-1:0] cx_z;
        logic signed [PROD_W-1:0] fy_y;
        logic signed [PROD_W-1:0] cy_z;
        logic [DEN_W-1:0]         den;
        logic [ZK_W-1:0]          z_k;
    } mul_stage_t;

    typedef struct packed {
        logic                    z_pos;
        logic signed [NUM_W-1:0] num_u;
        logic signed [NUM_W-1:0] num_v;
        logic [DEN_W-1:0]        den;
        logic [DEPTH_W-1:0]      depth;
    } sum_stage_t;

    typedef struct packed {
        logic               ok_u;
        logic               ok_v;
        logic [REM_W-1:0]   rem_u;
        logic [REM_W-1:0]   rem_v;
        logic [PIX_W-1:0]   q_u;
        logic [PIX_W-1:0]   q_v;
        logic [DEN_W-1:0]   den;
        logic [DEPTH_W-1:0] depth;
    } div_stage_t;

    logic       en;
    mul_stage_t s1_reg, s1_next;
    logic       s1_vld_reg;
    sum_stage_t s2_reg, s2_next;
    logic       s2_vld_reg;
    div_stage_t div_head;
    div_stage_t div_reg  [PIX_W+1];
    div_stage_t div_next [PIX_W+1];
    logic       div_vld_reg [PIX_W+1];
    pixel_t     out_reg, out_next;
    logic       out_vld_reg;

    logic [SIZE_W-1:0] lim_r, lim_c;
    logic [ZK_W-1:0]   mm_full;
    logic [NUM_W-1:0]  den_top;

    assign en      = !out_vld_reg || m_ready;
    assign q_pop   = en && q_valid;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    assign lim_r = (cfg.image_rows < SIZE_W'(ROW_CAP)) ? cfg.image_rows : SIZE_W'(ROW_CAP);
    assign lim_c = (cfg.image_cols < SIZE_W'(COL_CAP)) ? cfg.image_cols : SIZE_W'(COL_CAP);

    always_comb begin
        s1_next.z_pos = q_data.z_pos;
        s1_next.fx_x  = $signed({1'b0, cfg.focal_x}) * $signed(q_data.pt.point_x);
        s1_next.sk_y  = $signed(cfg.skew_term) * $signed(q_data.pt.point_y);
        s1_next.cx_z  = $signed({1'b0, cfg.center_x}) * $signed(q_data.pt.point_z);
        s1_next.fy_y  = $signed({1'b0, cfg.focal_y}) * $signed(q_data.pt.point_y);
        s1_next.cy_z  = $signed({1'b0, cfg.center_y}) * $signed(q_data.pt.point_z);
        s1_next.den   = {q_data.pt.point_z[COORD_W-2:0], FRAC_W'(0)};
        s1_next.z_k   = ZK_W'(q_data.pt.point_z[COORD_W-2:0]) * ZK_W'(MM_CONST);
    end

    always_comb begin
        mm_full        = s1_reg.z_k + ZK_W'(ROUND_HALF);
        s2_next.z_pos  = s1_reg.z_pos;
        s2_next.num_u  = NUM_W'(s1_reg.fx_x) + NUM_W'(s1_reg.sk_y) + NUM_W'(s1_reg.cx_z);
        s2_next.num_v  = NUM_W'(s1_reg.fy_y) + NUM_W'(s1_reg.cy_z);
        s2_next.den    = s1_reg.den;
        if (!s1_reg.z_pos) begin
            s2_next.depth = '0;
        end else if (mm_full[ZK_W-1:DEPTH_SHIFT+DEPTH_W] != '0) begin
            s2_next.depth = '1;
        end else begin
            s2_next.depth = mm_full[DEPTH_SHIFT+DEPTH_W-1:DEPTH_SHIFT];
        end
    end

    // quotient must stay below 2^PIX_W, otherwise the pixel is out of any image
    always_comb begin
        den_top        = NUM_W'({s2_reg.den, PIX_W'(0)});
        div_head.ok_u  = s2_reg.z_pos && !s2_reg.num_u[NUM_W-1]
                         && ($unsigned(s2_reg.num_u) < den_top);
        div_head.ok_v  = s2_reg.z_pos && !s2_reg.num_v[NUM_W-1]
                         && ($unsigned(s2_reg.num_v) < den_top);
        div_head.rem_u = s2_reg.num_u[REM_W-1:0];
        div_head.rem_v = s2_reg.num_v[REM_W-1:0];
        div_head.q_u   = '0;
        div_head.q_v   = '0;
        div_head.den   = s2_reg.den;
        div_head.depth = s2_reg.depth;
    end

    assign div_next[0] = div_head;

    for (genvar k = 1; k <= PIX_W; k++) begin : g_div
        ptdp_div_step #(.SHIFT(PIX_W - k)) u_step_u (
            .rem_in  (div_reg[k-1].rem_u),
            .den     (div_reg[k-1].den),
            .q_in    (div_reg[k-1].q_u),
            .rem_out (div_next[k].rem_u),
            .q_out   (div_next[k].q_u)
        );
        ptdp_div_step #(.SHIFT(PIX_W - k)) u_step_v (
            .rem_in  (div_reg[k-1].rem_v),
            .den     (div_reg[k-1].den),
            .q_in    (div_reg[k-1].q_v),
            .rem_out (div_next[k].rem_v),
            .q_out   (div_next[k].q_v)
        );
        assign div_next[k].ok_u  = div_reg[k-1].ok_u;
        assign div_next[k].ok_v  = div_reg[k-1].ok_v;
        assign div_next[k].den   = div_reg[k-1].den;
        assign div_next[k].depth = div_reg[k-1].depth;
    end

    always_comb begin
        out_next.in_range  = div_reg[PIX_W].ok_u && div_reg[PIX_W].ok_v
                             && ({1'b0, div_reg[PIX_W].q_u} < lim_c)
                             && ({1'b0, div_reg[PIX_W].q_v} < lim_r);
        out_next.pixel_row = out_next.in_range ? div_reg[PIX_W].q_v : '0;
        out_next.pixel_col = out_next.in_range ? div_reg[PIX_W].q_u : '0;
        out_next.depth_mm  = div_reg[PIX_W].depth;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i <= PIX_W; i++) begin
                div_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            s1_vld_reg     <= q_valid;
            s2_vld_reg     <= s1_vld_reg;
            div_vld_reg[0] <= s2_vld_reg;
            for (int i = 1; i <= PIX_W; i++) begin
                div_vld_reg[i] <= div_vld_reg[i-1];
            end
            out_vld_reg <= div_vld_reg[PIX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            out_reg <= out_next;
            for (int i = 0; i <= PIX_W; i++) begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    a_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_reg.in_range |->
            ({1'b0, out_reg.pixel_row} < lim_r) && ({1'b0, out_reg.pixel_col} < lim_c))
        else $error("in-range pixel outside image");

    a_out_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !out_reg.in_range |->
            out_reg.pixel_row == '0 && out_reg.pixel_col == '0)
        else $error("out-of-range pixel not zeroed");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(out_vld_reg) && $stable(div_vld_reg[PIX_W]))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

### rtl/point_to_depth_pixel_projection_core.sv
// Top level: configuration registers, front queue and back projection pipeline.
// Stages: 3 setup stages, 12 one-bit division stages and an output register.
// Throughput: one point per cycle while m_ready does not stall the output register.
// The 4-entry front queue lets input keep flowing while m_ready is low, until the queue is full.
// Reset (aresetn low, synchronous): queue and pipeline emptied, intrinsics cleared,
// image size back to 720 rows by 1280 columns.
`default_nettype none

module point_to_depth_pixel_projection_core import ptdp_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  point_t               s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output pixel_t               m_data,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_wdata
);

    cfg_t         cfg_reg, cfg_next;
    logic         q_valid;
    queue_entry_t q_data;
    logic         q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_FOCAL_X:    cfg_next.focal_x    = cfg_wdata;
                REG_FOCAL_Y:    cfg_next.focal_y    = cfg_wdata;
                REG_SKEW:       cfg_next.skew_term  = cfg_wdata;
                REG_CENTER_X:   cfg_next.center_x   = cfg_wdata;
                REG_CENTER_Y:   cfg_next.center_y   = cfg_wdata;
                REG_IMAGE_ROWS: cfg_next.image_rows = cfg_wdata[SIZE_W-1:0];
                REG_IMAGE_COLS: cfg_next.image_cols = cfg_wdata[SIZE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focal_x    <= '0;
            cfg_reg.focal_y    <= '0;
            cfg_reg.skew_term  <= '0;
            cfg_reg.center_x   <= '0;
            cfg_reg.center_y   <= '0;
            cfg_reg.image_rows <= SIZE_W'(RST_ROWS);
            cfg_reg.image_cols <= SIZE_W'(RST_COLS);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ptdp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    ptdp_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
